// ===== design/htcg_pkg.sv =====
// Shared types and constants for the height-to-colour gradient unit.
package htcg_pkg;

    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int HMAX_W  = 15;
    localparam int QUO_W   = CHAN_W;
    localparam int NUM_W   = HMAX_W + CHAN_W;
    localparam int NCHAN   = 3;

    // Register map, index taken from paddr[3:2]
    localparam logic [1:0] REG_ZERO_COLOR = 2'd0;
    localparam logic [1:0] REG_HIGH_COLOR = 2'd1;
    localparam logic [1:0] REG_LOW_COLOR  = 2'd2;
    localparam logic [1:0] REG_HEIGHT_MAX = 2'd3;

    localparam logic [COLOR_W-1:0] ZERO_COLOR_RST = 24'h000000;
    localparam logic [COLOR_W-1:0] HIGH_COLOR_RST = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] LOW_COLOR_RST  = 24'h0000FF;
    localparam logic [HMAX_W-1:0]  HEIGHT_MAX_RST = 15'd1;

    // What the output stage picks for a beat
    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_END,
        MODE_BLEND
    } mode_t;

endpackage

// ===== design/htcg_divider.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
module htcg_divider (
    input  logic                        clk,
    input  logic [htcg_pkg::QUO_W-1:0]  load,
    input  logic [htcg_pkg::HMAX_W-1:0] hm,
    input  logic [htcg_pkg::NUM_W-1:0]  num,
    output logic [htcg_pkg::QUO_W-1:0]  quo
);
    import htcg_pkg::*;

    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    // Quotient is known to be below 2^QUO_W, so the top bit goes first
    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        logic [NUM_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [NUM_W-1:0] dsr;
        logic             ge;

        if (j == 0) begin : g_first
            assign rem_in = num;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign dsr = NUM_W'(hm) << (QUO_W - 1 - j);
        assign ge  = (rem_in >= dsr);

        always_ff @(posedge clk)
        begin
            if (load[j])
            begin
                rem_reg[j] <= ge ? (rem_in - dsr) : rem_in;
                quo_reg[j] <= {quo_in[QUO_W-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

// ===== design/height_to_color_gradient_unit.sv =====
// Top level of the height-to-colour gradient unit: pipeline and register port.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  input    | height_valid/_stall  | height [HEIGHT_WIDTH-1:0] signed
//  output   | color_valid/_stall   | color [23:0] (R 23..16, B 7..0)
//  config   | APB, pready tied hi  | 4 registers at 0x0,0x4,0x8,0xC
//
// One beat per cycle sustained while the output is not stalled; stages are the magnitude/clamp stage,
// multiply-accumulate stage, eight restoring division steps (one quotient
// bit each, three channels side by side), and the output register.
// Every stage holds its beat under stall and empty stages fill up, so input
// keeps flowing while the output waits. Reset clears valid bits and loads
// the register defaults.
module height_to_color_gradient_unit #(
    parameter int HEIGHT_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          height_valid,
    output logic                          height_stall,
    input  logic signed [HEIGHT_WIDTH-1:0] height,
    // output stream
    output logic                          color_valid,
    input  logic                          color_stall,
    output logic [htcg_pkg::COLOR_W-1:0]  color,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import htcg_pkg::*;

    localparam int STAGES  = QUO_W + 3;
    localparam int DIV_LO  = 2;
    localparam int DIV_HI  = DIV_LO + QUO_W - 1;
    localparam int OUT_STG = STAGES - 1;
    localparam int CMP_W   = HEIGHT_WIDTH + HMAX_W;

    // ---------------- configuration registers ----------------
    logic [COLOR_W-1:0] zero_color_reg;
    logic [COLOR_W-1:0] high_color_reg;
    logic [COLOR_W-1:0] low_color_reg;
    logic [HMAX_W-1:0]  height_max_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_color_reg <= ZERO_COLOR_RST;
            high_color_reg <= HIGH_COLOR_RST;
            low_color_reg  <= LOW_COLOR_RST;
            height_max_reg <= HEIGHT_MAX_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ZERO_COLOR: zero_color_reg <= pwdata[COLOR_W-1:0];
                REG_HIGH_COLOR: high_color_reg <= pwdata[COLOR_W-1:0];
                REG_LOW_COLOR:  low_color_reg  <= pwdata[COLOR_W-1:0];
                REG_HEIGHT_MAX: height_max_reg <= pwdata[HMAX_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (paddr[3:2])
            REG_ZERO_COLOR: prdata = 32'(zero_color_reg);
            REG_HIGH_COLOR: prdata = 32'(high_color_reg);
            REG_LOW_COLOR:  prdata = 32'(low_color_reg);
            REG_HEIGHT_MAX: prdata = 32'(height_max_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // a stage loads when empty or when the next one loads
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] load;

    always_comb
    begin
        load[OUT_STG] = !valid_reg[OUT_STG] || !color_stall;
        for (int k = OUT_STG - 1; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign height_stall = !load[0];
    assign color_valid  = valid_reg[OUT_STG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= height_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: magnitude, clamp, mode ----------------
    logic                     neg;
    logic [HEIGHT_WIDTH-1:0]  mag;
    logic [CMP_W-1:0]         mag_ext;
    mode_t                    mode_next;

    assign neg     = height[HEIGHT_WIDTH-1];
    assign mag     = neg ? (~height + 1'b1) : height;
    assign mag_ext = CMP_W'(mag);

    always_comb
    begin
        if (height == '0)
            mode_next = MODE_ZERO;
        else if (mag_ext < CMP_W'(height_max_reg))
            mode_next = MODE_BLEND;
        else
            mode_next = MODE_END;
    end

    mode_t              mode_reg [OUT_STG];
    logic [COLOR_W-1:0] end_reg  [OUT_STG];
    logic [HMAX_W-1:0]  f_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            mode_reg[0] <= mode_next;
            end_reg[0]  <= neg ? low_color_reg : high_color_reg;
            f_reg       <= mag_ext[HMAX_W-1:0];
        end
    end

    // mode and end colour ride alongside the arithmetic
    for (genvar k = 1; k < OUT_STG; k++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (load[k])
            begin
                mode_reg[k] <= mode_reg[k-1];
                end_reg[k]  <= end_reg[k-1];
            end
        end
    end

    // ---------------- stage 1: weighted sum per channel ----------------
    logic [HMAX_W-1:0] hm_minus_f;
    logic [NUM_W-1:0]  num_reg [NCHAN];
    logic [CHAN_W-1:0] quo     [NCHAN];

    assign hm_minus_f = height_max_reg - f_reg;

    for (genvar c = 0; c < NCHAN; c++) begin : g_chan
        logic [CHAN_W-1:0] c0;
        logic [CHAN_W-1:0] c1;

        assign c0 = zero_color_reg[c*CHAN_W +: CHAN_W];
        assign c1 = end_reg[0][c*CHAN_W +: CHAN_W];

        always_ff @(posedge clk)
        begin
            if (load[1])
            begin
                num_reg[c] <= NUM_W'(c0) * NUM_W'(hm_minus_f)
                            + NUM_W'(c1) * NUM_W'(f_reg);
            end
        end

        // stages 2..9: division by height_max
        htcg_divider u_div (
            .clk  (clk),
            .load (load[DIV_HI:DIV_LO]),
            .hm   (height_max_reg),
            .num  (num_reg[c]),
            .quo  (quo[c])
        );
    end

    // ---------------- output register ----------------
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;

    always_comb
    begin
        case (mode_reg[DIV_HI])
            MODE_ZERO:  color_next = zero_color_reg;
            MODE_END:   color_next = end_reg[DIV_HI];
            MODE_BLEND: color_next = {quo[2], quo[1], quo[0]};
            default:    color_next = end_reg[DIV_HI];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load[OUT_STG])
        begin
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

// ===== dv/htcg_color_check.sv =====
// Scoreboard for the gradient unit: watches both streams and the register port.
module htcg_color_check (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         height_valid,
    input  logic                         height_stall,
    input  logic [15:0]                  height,
    input  logic                         color_valid,
    input  logic                         color_stall,
    input  logic [htcg_pkg::COLOR_W-1:0] color,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    output int                           fail_count,
    output int                           pending,
    output int                           colors_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import htcg_pkg::*;

    // own copy of the register file
    logic [COLOR_W-1:0] zero_col;
    logic [COLOR_W-1:0] high_col;
    logic [COLOR_W-1:0] low_col;
    logic [HMAX_W-1:0]  hmax;

    logic [COLOR_W-1:0] color_due_q[$];
    logic [COLOR_W-1:0] due;
    logic [31:0]        reg_val;
    int                 shown;

    // colour for one height under the current registers
    function automatic logic [COLOR_W-1:0] gradient_color(input logic [15:0] h);
        logic [16:0]        mag;
        logic [COLOR_W-1:0] end_col;
        logic [COLOR_W-1:0] col;
        logic [31:0]        c0;
        logic [31:0]        c1;
        logic [31:0]        m;
        logic [31:0]        hm;
        logic [31:0]        quo;
        mag     = h[15] ? (17'h10000 - {1'b0, h}) : {1'b0, h};
        end_col = h[15] ? low_col : high_col;
        hm      = {17'd0, hmax};
        m       = {15'd0, mag};
        col     = '0;
        if (h == 16'd0)
            col = zero_col;
        else if (hm == 0 || m >= hm)
            col = end_col;
        else
        begin
            for (int ch = 0; ch < NCHAN; ch++)
            begin
                c0  = {24'd0, zero_col[ch*CHAN_W +: CHAN_W]};
                c1  = {24'd0, end_col[ch*CHAN_W +: CHAN_W]};
                quo = (c0 * (hm - m) + c1 * m) / hm;
                col[ch*CHAN_W +: CHAN_W] = quo[CHAN_W-1:0];
            end
        end
        return col;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        if (shown < 10)
        begin
            shown++;
            $display("%0t ns  %s: expected %06h, got %06h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_col       = ZERO_COLOR_RST;
            high_col       = HIGH_COLOR_RST;
            low_col        = LOW_COLOR_RST;
            hmax           = HEIGHT_MAX_RST;
            color_due_q.delete();
            fail_count     = 0;
            pending        = 0;
            colors_checked = 0;
            shown          = 0;
        end
        else
        begin
            // colour beat against the oldest prediction
            if (color_valid && !color_stall)
            begin
                if (color_due_q.size() == 0)
                    note_mismatch("colour beat with nothing outstanding", 32'd0,
                                  32'(color));
                else
                begin
                    due = color_due_q.pop_front();
                    colors_checked++;
                    if (color !== due)
                        note_mismatch("colour", 32'(due), 32'(color));
                end
            end

            // height beat: predict its colour
            if (height_valid && !height_stall)
                color_due_q.push_back(gradient_color(height));

            // register access phase
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        REG_ZERO_COLOR: zero_col = pwdata[COLOR_W-1:0];
                        REG_HIGH_COLOR: high_col = pwdata[COLOR_W-1:0];
                        REG_LOW_COLOR:  low_col  = pwdata[COLOR_W-1:0];
                        REG_HEIGHT_MAX: hmax     = pwdata[HMAX_W-1:0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (paddr[3:2])
                        REG_ZERO_COLOR: reg_val = {8'd0, zero_col};
                        REG_HIGH_COLOR: reg_val = {8'd0, high_col};
                        REG_LOW_COLOR:  reg_val = {8'd0, low_col};
                        default:        reg_val = {17'd0, hmax};
                    endcase
                    if (prdata !== reg_val)
                        note_mismatch("register readback", reg_val, prdata);
                end
            end

            pending = color_due_q.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Top of the gradient unit testbench: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import htcg_pkg::*;

    localparam int HEIGHT_W    = 16;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE      = 16;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 110;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                height_valid = 1'b0;
    logic                height_stall;
    logic [HEIGHT_W-1:0] height = '0;
    logic                color_valid;
    logic                color_stall = 1'b0;
    logic [COLOR_W-1:0]  color;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [3:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    int fail_count;
    int pending;
    int colors_checked;
    int heights_sent = 0;
    int settings_used = 0;
    int idle_cycles = 0;
    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;

    always #5 clk = ~clk;

    height_to_color_gradient_unit #(
        .HEIGHT_WIDTH(HEIGHT_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .height_valid (height_valid),
        .height_stall (height_stall),
        .height       (height),
        .color_valid  (color_valid),
        .color_stall  (color_stall),
        .color        (color),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    htcg_color_check u_color_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .height_valid   (height_valid),
        .height_stall   (height_stall),
        .height         (height),
        .color_valid    (color_valid),
        .color_stall    (color_stall),
        .color          (color),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .colors_checked (colors_checked)
    );

    // colour side: when rx_idle is set, a random stall before each beat
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            n = rx_idle ? $urandom_range(0, 4) : 0;
            if (n > 0)
            begin
                color_stall <= 1'b1;
                repeat (n) @(negedge clk);
                color_stall <= 1'b0;
            end
            do @(posedge clk); while (!(color_valid && !color_stall));
        end
    end

    // watchdog on cycles with no beat and no register access
    always @(posedge clk)
    begin
        if ((height_valid && !height_stall) || (color_valid && !color_stall) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one height beat, with an optional gap in front
    task automatic drive_height(input int h);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            height_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        height_valid <= 1'b1;
        height       <= h[HEIGHT_W-1:0];
        do @(posedge clk); while (height_stall);
        heights_sent++;
    endtask

    // stop sending and wait for every colour to come back
    task automatic drain();
        @(negedge clk);
        height_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // APB setup then access phase
    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_gradient(input logic [23:0] zc, input logic [23:0] hc,
                                input logic [23:0] lc, input logic [14:0] hm);
        apb_access(1'b1, REG_ZERO_COLOR, {8'd0, zc});
        apb_access(1'b1, REG_HIGH_COLOR, {8'd0, hc});
        apb_access(1'b1, REG_LOW_COLOR, {8'd0, lc});
        apb_access(1'b1, REG_HEIGHT_MAX, {17'd0, hm});
        apb_access(1'b0, REG_ZERO_COLOR, '0);
        apb_access(1'b0, REG_HIGH_COLOR, '0);
        apb_access(1'b0, REG_LOW_COLOR, '0);
        apb_access(1'b0, REG_HEIGHT_MAX, '0);
        settings_used++;
    endtask

    // mostly inside the gradient, some saturated, some anywhere
    function automatic int pick_height(input int hm);
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel <= 5)
            v = $urandom_range(0, hm + 1);
        else if (sel == 6)
            v = $urandom_range(0, 65535) - 32768;
        else if (sel == 7)
        begin
            case ($urandom_range(0, 4))
                0: v = hm;
                1: v = hm + 1;
                2: v = (hm > 0) ? hm - 1 : 0;
                3: v = 32767;
                default: v = 32768;
            endcase
        end
        else
            v = $urandom_range(0, 3);
        if ($urandom_range(0, 1) == 1)
            v = -v;
        if (v > 32767)
            v = 32767;
        return v;
    endfunction

    initial
    begin
        int reset_heights[7]  = '{0, 1, -1, 2, -2, 32767, -32768};
        int blend_heights[14] = '{0, 1, 50, 99, 100, 101, 32767,
                                  -1, -50, -99, -100, -101, -32767, -32768};
        int flat_heights[5]   = '{0, 5, -5, 32767, -32768};
        logic [23:0] zc;
        logic [23:0] hc;
        logic [23:0] lc;
        int hm;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values, then the unit-range default gradient
        apb_access(1'b0, REG_ZERO_COLOR, '0);
        apb_access(1'b0, REG_HIGH_COLOR, '0);
        apb_access(1'b0, REG_LOW_COLOR, '0);
        apb_access(1'b0, REG_HEIGHT_MAX, '0);
        foreach (reset_heights[i]) drive_height(reset_heights[i]);
        drain();

        // blend region, both edges of the clamp, most negative height
        set_gradient(24'h102030, 24'hF0E0D0, 24'h0A0B0C, 15'd100);
        foreach (blend_heights[i]) drive_height(blend_heights[i]);
        drain();

        // zero height_max: nonzero heights go straight to the end colour
        set_gradient(24'hFFFFFF, 24'h000000, 24'h5A5A5A, 15'd0);
        foreach (flat_heights[i]) drive_height(flat_heights[i]);
        drain();

        // random phases, each under its own gradient
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            zc = 24'($urandom_range(0, 24'hFFFFFF));
            hc = 24'($urandom_range(0, 24'hFFFFFF));
            lc = 24'($urandom_range(0, 24'hFFFFFF));
            if (p == 0)
            begin
                zc = 24'hFFFFFF;
                hc = 24'h000000;
                lc = 24'h000000;
            end
            else if (p == 1)
            begin
                zc = 24'h000000;
                hc = 24'hFFFFFF;
                lc = 24'hFFFFFF;
            end
            case (p % 5)
                0: hm = 32767;
                1: hm = 0;
                2: hm = 1;
                3: hm = $urandom_range(2, 255);
                default: hm = $urandom_range(256, 32767);
            endcase
            set_gradient(zc, hc, lc, hm[14:0]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // each stretch of 32 heights picks anew whether to idle on either side
                if (n % 32 == 0)
                begin
                    tx_idle = ($urandom_range(0, 3) != 0);
                    rx_idle = ($urandom_range(0, 3) != 0);
                end
                drive_height(pick_height(hm));
            end
            drain();
        end

        repeat (SETTLE) @(posedge clk);
        $display("Sent %0d heights under %0d gradient settings; %0d colours checked.",
                 heights_sent, settings_used, colors_checked);
        $display("Settings spanned height_max of 0, 1 and full scale with extreme colours.");
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
design/htcg_pkg.sv
design/htcg_divider.sv
design/height_to_color_gradient_unit.sv
dv/htcg_color_check.sv
dv/tb_top.sv
